FILE: hw/rtl/four_level_page_table_walker_defines.svh
// Assertion macros for the four-level page table walker checker.
// No dependencies; included by the checker file.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PGW_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PGW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/pgwalk_pkg.sv
// Shared types and constants for the four-level page table walker.
// No dependencies; used by the top level and its checker.
package pgwalk_pkg;

    localparam int STORE_WORDS_DEF   = 4096;
    localparam int LEVEL_INDEX_BITS  = 9;
    localparam int TABLE_ENTRIES     = 1 << LEVEL_INDEX_BITS;
    localparam int PA_BITS           = 52;
    localparam int VA_BITS           = 48;
    localparam int OFFSET_BITS       = 12;
    localparam int BASE_BITS         = PA_BITS - OFFSET_BITS;
    localparam int WORD_BITS         = 64;
    localparam int IDX_BITS          = 12;
    localparam int PRESENT_POS       = 0;
    localparam int SIZE_POS          = 7;
    localparam int GIGA_BITS         = 30;
    localparam int MEGA2_BITS        = 21;
    localparam int IN_TDATA_BITS     = 128;
    localparam int OUT_TDATA_BITS    = 56;
    localparam int OUT_TUSER_BITS    = 3;

    typedef enum logic {
        CMD_WRITE     = 1'b0,
        CMD_TRANSLATE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        PAGE_4K = 2'd0,
        PAGE_2M = 2'd1,
        PAGE_1G = 2'd2
    } page_size_t;

    typedef enum logic [1:0] {
        FAULT_NONE        = 2'd0,
        FAULT_NOT_PRESENT = 2'd1,
        FAULT_OUTSIDE     = 2'd2
    } fault_kind_t;

    typedef enum logic [1:0] {
        LVL_TOP = 2'd0,
        LVL_DIR_PTR = 2'd1,
        LVL_DIR = 2'd2,
        LVL_LAST = 2'd3
    } level_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOKUP = 4'b0010,
        ST_EVAL   = 4'b0100,
        ST_DONE   = 4'b1000
    } walk_state_t;

endpackage

FILE: hw/rtl/four_level_page_table_walker.sv
// Four-level page table walker: top level with table store and walk sequencer.
// Depends on pgwalk_pkg.
//
// Usage:
//   s_ carries one item per handshake; s_tuser is the command. A write item
//   loads one 64-bit word into the table store (index below STORE_WORDS,
//   otherwise dropped) and gives no result. A translate item walks the tables
//   from root_table_base and gives one result item on m_.
//   cfg_we/cfg_wdata load root_table_base (low 12 bits ignored); write it only
//   while the block is idle.
// Walk sequence:
//   A write item needs no walk; the next item may follow at once.
//   A translate item passes a check-and-read state (ST_LOOKUP) and a decode
//   state (ST_EVAL) per level (a table outside the store faults in its check
//   state), then ST_DONE loads the output register; the next item can be taken
//   in the cycle after that load. The walk is serial: the single store read
//   port serves one level at a time, and each level needs the entry of the level above.
//   s_tready stays low from a translate acceptance until its result is loaded.
// Reset: aresetn clears the sequencer, the output valid and root_table_base;
//   the table store is not cleared, so read only words that were written.
// Stall: the result holds on m_ until taken; items are still accepted while it
//   waits, but a finished walk holds in its last state until the register frees.
module four_level_page_table_walker #(
    parameter int STORE_WORDS = pgwalk_pkg::STORE_WORDS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration: root_table_base
    input  logic                                 cfg_we,
    input  logic [pgwalk_pkg::PA_BITS-1:0]       cfg_wdata,
    // input items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [47:0] virt_addr, [59:48] store_index, [123:60] store_data, [127:124] zero
    input  logic [pgwalk_pkg::IN_TDATA_BITS-1:0] s_tdata,
    // [0] cmd
    input  logic                                 s_tuser,
    // result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [51:0] phys_addr, [53:52] page_size, [55:54] fault_level
    output logic [pgwalk_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    // [0] ok, [2:1] fault_kind
    output logic [pgwalk_pkg::OUT_TUSER_BITS-1:0] m_tuser
);

    localparam int AW = $clog2(STORE_WORDS);
    localparam int FIRST_BITS = pgwalk_pkg::PA_BITS - 3;
    localparam logic [FIRST_BITS-1:0] FIRST_MAX =
        FIRST_BITS'(STORE_WORDS - pgwalk_pkg::TABLE_ENTRIES);

    // Input field split
    logic [pgwalk_pkg::VA_BITS-1:0]   s_virt_addr;
    logic [pgwalk_pkg::IDX_BITS-1:0]  s_store_index;
    logic [pgwalk_pkg::WORD_BITS-1:0] s_store_data;
    logic                             s_accept;

    assign s_virt_addr   = s_tdata[47:0];
    assign s_store_index = s_tdata[59:48];
    assign s_store_data  = s_tdata[123:60];
    assign s_accept      = s_tvalid && s_tready;

    // Table store
    logic [pgwalk_pkg::WORD_BITS-1:0] store_mem [STORE_WORDS];
    logic [pgwalk_pkg::WORD_BITS-1:0] rd_data_reg;

    // Control and walk state
    pgwalk_pkg::walk_state_t          state_reg, state_next;
    logic [pgwalk_pkg::BASE_BITS-1:0] root_base_reg;
    logic [pgwalk_pkg::BASE_BITS-1:0] table_base_reg, table_base_next;
    logic [pgwalk_pkg::VA_BITS-1:0]   va_reg, va_next;
    logic [1:0]                       level_reg, level_next;

    // Pending result, waits in ST_DONE for the output register
    logic [pgwalk_pkg::PA_BITS-1:0]   res_pa_reg, res_pa_next;
    logic                             res_ok_reg, res_ok_next;
    logic [1:0]                       res_size_reg, res_size_next;
    logic [1:0]                       res_kind_reg, res_kind_next;
    logic [1:0]                       res_level_reg, res_level_next;

    // Output register
    logic                                 m_valid_reg, m_valid_next;
    logic [pgwalk_pkg::OUT_TDATA_BITS-1:0] m_data_reg, m_data_next;
    logic [pgwalk_pkg::OUT_TUSER_BITS-1:0] m_user_reg, m_user_next;

    // Shared address unit: table bounds check and entry address
    logic [FIRST_BITS-1:0]                   first_word;
    logic                                    table_outside;
    logic [pgwalk_pkg::LEVEL_INDEX_BITS-1:0] level_idx;
    logic [AW-1:0]                           lookup_addr;
    logic                                    wr_en;

    assign first_word    = {table_base_reg, {(pgwalk_pkg::LEVEL_INDEX_BITS){1'b0}}};
    assign table_outside = first_word > FIRST_MAX;

    always_comb begin
        case (level_reg)
            pgwalk_pkg::LVL_TOP:     level_idx = va_reg[47:39];
            pgwalk_pkg::LVL_DIR_PTR: level_idx = va_reg[38:30];
            pgwalk_pkg::LVL_DIR:     level_idx = va_reg[29:21];
            default:                 level_idx = va_reg[20:12];
        endcase
    end

    // Tables are aligned to 512 words, so the index fills the low bits.
    assign lookup_addr = AW'(first_word) | AW'(level_idx);

    assign wr_en = s_accept && (s_tuser == pgwalk_pkg::CMD_WRITE) &&
                   (32'(s_store_index) < STORE_WORDS);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[AW'(s_store_index)] <= s_store_data;
        end
        if (state_reg == pgwalk_pkg::ST_LOOKUP) begin
            rd_data_reg <= store_mem[lookup_addr];
        end
    end

    // Take items only between walks; a translate accepted here starts the next walk.
    assign s_tready = (state_reg == pgwalk_pkg::ST_IDLE);

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        table_base_next = table_base_reg;
        va_next         = va_reg;
        level_next      = level_reg;
        res_pa_next     = res_pa_reg;
        res_ok_next     = res_ok_reg;
        res_size_next   = res_size_reg;
        res_kind_next   = res_kind_reg;
        res_level_next  = res_level_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;

        case (state_reg)
            pgwalk_pkg::ST_IDLE: begin
                if (s_accept && s_tuser == pgwalk_pkg::CMD_TRANSLATE) begin
                    va_next         = s_virt_addr;
                    table_base_next = root_base_reg;
                    level_next      = pgwalk_pkg::LVL_TOP;
                    state_next      = pgwalk_pkg::ST_LOOKUP;
                end
            end
            pgwalk_pkg::ST_LOOKUP: begin
                if (table_outside) begin
                    res_pa_next    = '0;
                    res_ok_next    = 1'b0;
                    res_size_next  = pgwalk_pkg::PAGE_4K;
                    res_kind_next  = pgwalk_pkg::FAULT_OUTSIDE;
                    res_level_next = level_reg;
                    state_next     = pgwalk_pkg::ST_DONE;
                end else begin
                    state_next = pgwalk_pkg::ST_EVAL;
                end
            end
            pgwalk_pkg::ST_EVAL: begin
                res_ok_next    = 1'b1;
                res_kind_next  = pgwalk_pkg::FAULT_NONE;
                res_level_next = pgwalk_pkg::LVL_TOP;
                res_size_next  = pgwalk_pkg::PAGE_4K;
                res_pa_next    = {rd_data_reg[51:12], va_reg[11:0]};
                state_next     = pgwalk_pkg::ST_DONE;
                if (!rd_data_reg[pgwalk_pkg::PRESENT_POS]) begin
                    res_pa_next    = '0;
                    res_ok_next    = 1'b0;
                    res_kind_next  = pgwalk_pkg::FAULT_NOT_PRESENT;
                    res_level_next = level_reg;
                end else if (level_reg == pgwalk_pkg::LVL_DIR_PTR &&
                             rd_data_reg[pgwalk_pkg::SIZE_POS]) begin
                    res_size_next = pgwalk_pkg::PAGE_1G;
                    res_pa_next   = {rd_data_reg[51:30], va_reg[29:0]};
                end else if (level_reg == pgwalk_pkg::LVL_DIR &&
                             rd_data_reg[pgwalk_pkg::SIZE_POS]) begin
                    res_size_next = pgwalk_pkg::PAGE_2M;
                    res_pa_next   = {rd_data_reg[51:21], va_reg[20:0]};
                end else if (level_reg != pgwalk_pkg::LVL_LAST) begin
                    // descend: the entry names the next table
                    table_base_next = rd_data_reg[51:12];
                    level_next      = level_reg + 2'd1;
                    state_next      = pgwalk_pkg::ST_LOOKUP;
                end
            end
            pgwalk_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {res_level_reg, res_size_reg, res_pa_reg};
                    m_user_next  = {res_kind_reg, res_ok_reg};
                    state_next   = pgwalk_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pgwalk_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pgwalk_pkg::ST_IDLE;
            root_base_reg <= '0;
            level_reg     <= pgwalk_pkg::LVL_TOP;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            level_reg   <= level_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                root_base_reg <= cfg_wdata[51:12];
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        table_base_reg <= table_base_next;
        va_reg         <= va_next;
        res_pa_reg     <= res_pa_next;
        res_ok_reg     <= res_ok_next;
        res_size_reg   <= res_size_next;
        res_kind_reg   <= res_kind_next;
        res_level_reg  <= res_level_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

FILE: hw/rtl/pgwalk_checker.sv
// Port-level checker for the four-level page table walker, with its bind.
// Depends on pgwalk_pkg and four_level_page_table_walker_defines.svh.
`include "four_level_page_table_walker_defines.svh"

module pgwalk_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic                                  s_tuser,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [pgwalk_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    input logic [pgwalk_pkg::OUT_TUSER_BITS-1:0] m_tuser
);

    // A stalled result holds.
    `PGW_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // A good translation carries no fault and a legal page size.
    `PGW_ASSERT_NOW(a_ok_clean, aclk, aresetn, m_tvalid && m_tuser[0], m_tuser[2:1] == pgwalk_pkg::FAULT_NONE && m_tdata[55:54] == pgwalk_pkg::LVL_TOP && m_tdata[53:52] != 2'd3, "ok result with fault fields")

    // A fault names a kind and carries a zero address and size.
    `PGW_ASSERT_NOW(a_fault_clean, aclk, aresetn, m_tvalid && !m_tuser[0], (m_tuser[2:1] == pgwalk_pkg::FAULT_NOT_PRESENT || m_tuser[2:1] == pgwalk_pkg::FAULT_OUTSIDE) && m_tdata[53:0] == '0, "fault result malformed")

    // A translate item starts a walk that holds off the input.
    `PGW_ASSERT_NEXT(a_walk_busy, aclk, aresetn, s_tvalid && s_tready && s_tuser == pgwalk_pkg::CMD_TRANSLATE, !s_tready, "input ready during a walk")

endmodule

bind four_level_page_table_walker pgwalk_checker u_pgwalk_checker (.*);

FILE: test/tb_four_level_page_table_walker.sv
// Self-checking testbench for four_level_page_table_walker: page tables are built
// through write items, translations are predicted in the bench and checked per field.
// Depends on pgwalk_pkg and the four_level_page_table_walker top level.
`timescale 1ns / 100ps

module tb_four_level_page_table_walker;

    localparam int ITEMS_TARGET = 1700;
    localparam int IDLE_PCT     = 15;
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_CYCLES = 600000;
    localparam int STALL_CYCLES = 400;
    localparam int RECENT_MAX   = 32;

    // One translation result as the block reports it.
    typedef struct packed {
        logic [51:0]             pa;
        logic                    ok;
        pgwalk_pkg::page_size_t  size;
        pgwalk_pkg::fault_kind_t kind;
        pgwalk_pkg::level_t      lvl;
    } walk_result_t;

    logic                                  aclk;
    logic                                  aresetn   = 1'b0;
    logic                                  cfg_we    = 1'b0;
    logic [pgwalk_pkg::PA_BITS-1:0]        cfg_wdata = '0;
    logic                                  s_tvalid  = 1'b0;
    logic                                  s_tready;
    logic [pgwalk_pkg::IN_TDATA_BITS-1:0]  s_tdata   = '0;
    logic                                  s_tuser   = 1'b0;
    logic                                  m_tvalid;
    logic                                  m_tready  = 1'b0;
    logic [pgwalk_pkg::OUT_TDATA_BITS-1:0] m_tdata;
    logic [pgwalk_pkg::OUT_TUSER_BITS-1:0] m_tuser;

    // Bench copy of the table store, the root register and the written marks.
    logic [63:0]  tbl_mem     [0:pgwalk_pkg::STORE_WORDS_DEF-1];
    bit           tbl_written [0:pgwalk_pkg::STORE_WORDS_DEF-1];
    logic [51:0]  root_base = '0;

    walk_result_t pending_xlat[$];
    logic [47:0]  recent_va[$];
    int           items_sent   = 0;
    int           mismatches   = 0;
    int           cycle_count  = 0;
    int           hold_cycles  = 0;
    bit           calm         = 1'b0;

    four_level_page_table_walker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Walk the bench tables for one virtual address. When the walk would read a
    // word that was never written, flag it as blind and name the word in hole.
    function automatic walk_result_t predict_walk(input logic [47:0] va, output bit blind,
                                                  output logic [11:0] hole);
        walk_result_t r;
        logic [51:0]  tbl;
        logic [47:0]  sh;
        logic [11:0]  widx;
        logic [63:0]  ent;
        r      = '0;
        blind  = 1'b0;
        hole   = '0;
        tbl    = {root_base[51:12], 12'h000};
        for (int lvl = 0; lvl < 4; lvl++) begin
            r.lvl = pgwalk_pkg::level_t'(lvl);
            // a table is in the store only below 0x8000 (eight tables of 4 KB)
            if (tbl[51:15] != '0) begin
                r.kind = pgwalk_pkg::FAULT_OUTSIDE;
                return r;
            end
            sh   = va >> (39 - 9 * lvl);
            widx = {tbl[14:12], sh[8:0]};
            if (!tbl_written[widx]) begin
                blind = 1'b1;
                hole  = widx;
                return r;
            end
            ent = tbl_mem[widx];
            if (!ent[pgwalk_pkg::PRESENT_POS]) begin
                r.kind = pgwalk_pkg::FAULT_NOT_PRESENT;
                return r;
            end
            // page-size bit counts only at the middle two levels
            if (lvl == 1 && ent[pgwalk_pkg::SIZE_POS]) begin
                r     = '0;
                r.ok  = 1'b1;
                r.size = pgwalk_pkg::PAGE_1G;
                r.pa  = {ent[51:30], va[29:0]};
                return r;
            end
            if (lvl == 2 && ent[pgwalk_pkg::SIZE_POS]) begin
                r     = '0;
                r.ok  = 1'b1;
                r.size = pgwalk_pkg::PAGE_2M;
                r.pa  = {ent[51:21], va[20:0]};
                return r;
            end
            if (lvl == 3) begin
                r     = '0;
                r.ok  = 1'b1;
                r.size = pgwalk_pkg::PAGE_4K;
                r.pa  = {ent[51:12], va[11:0]};
                return r;
            end
            tbl = {ent[51:12], 12'h000};
        end
        return r;
    endfunction

    // Random entry: mostly present pointers into the store, some just past its end.
    function automatic logic [63:0] random_entry();
        logic [63:0] e;
        int          k;
        e = rand64();
        k = $urandom_range(99);
        if (k < 78)
            e[51:15] = '0;
        else if (k < 88)
            e[51:15] = 37'h1;
        e[pgwalk_pkg::PRESENT_POS] = ($urandom_range(99) < 88);
        e[pgwalk_pkg::SIZE_POS]    = ($urandom_range(99) < 25);
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want,
                 cycle_count);
        mismatches++;
    endtask

    // Offer one item, hold it until accepted, then update the bench state.
    task automatic send_item(pgwalk_pkg::cmd_t cmd, logic [47:0] va, logic [11:0] idx,
                             logic [63:0] data);
        walk_result_t r;
        bit           blind;
        logic [11:0]  hole;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'h0, data, idx, va};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (cmd == pgwalk_pkg::CMD_WRITE) begin
            tbl_mem[idx]     = data;
            tbl_written[idx] = 1'b1;
        end else begin
            r = predict_walk(va, blind, hole);
            pending_xlat.push_back(r);
        end
    endtask

    // Fill any unwritten word on the walk path first, then translate.
    task automatic translate_va(logic [47:0] va);
        walk_result_t r;
        bit           blind;
        logic [11:0]  hole;
        logic [63:0]  fill;
        r = predict_walk(va, blind, hole);
        while (blind) begin
            fill = rand64();
            send_item(pgwalk_pkg::CMD_WRITE, fill[47:0], hole, random_entry());
            r = predict_walk(va, blind, hole);
        end
        fill = rand64();
        send_item(pgwalk_pkg::CMD_TRANSLATE, va, fill[11:0], rand64());
        recent_va.push_back(va);
        if (recent_va.size() > RECENT_MAX)
            void'(recent_va.pop_front());
    endtask

    task automatic write_word(logic [11:0] idx, logic [63:0] data);
        send_item(pgwalk_pkg::CMD_WRITE, 48'hFFFF_FFFF_FFFF, idx, data);
    endtask

    // Stop offering, wait for every result, then let the block settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_xlat.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_root(logic [51:0] base);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= base;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        root_base  = base;
    endtask

    // Root left at its reset value: top-level not present, then a pointer past the store.
    task automatic test_reset_root();
        write_word(12'd0, 64'h0);
        translate_va(48'h0);
        write_word(12'd0, {12'h000, 40'hFF_FFFF_FFFF, 12'hFFF});
        translate_va(48'h0);
    endtask

    // Root tables outside the store fault at the top level.
    task automatic test_root_outside();
        set_root(52'hF_FFFF_FFFF_FFFF);
        translate_va(48'h0);
        set_root(52'h0_0000_0000_8000);
        translate_va(48'hFFFF_FFFF_FFFF);
    endtask

    // Root in the last table with PCID bits set; all-ones indices hit the last
    // word of tables 7, 6, 5 and 4. Top-level size bit must be ignored.
    task automatic test_page_sizes();
        set_root(52'h0_0000_0000_7FFF);
        write_word(12'd4095, {12'hFFF, 40'h6, 12'h081});
        write_word(12'd3583, 64'hFFFF_FFFF_FFFF_FFFF);
        translate_va(48'hFFFF_FFFF_FFFF);
        write_word(12'd3583, {12'h000, 40'h5, 12'h001});
        write_word(12'd3071, {12'hFFF, 40'hFF_FFFF_FFFF, 12'h081});
        translate_va(48'hFFFF_FFFF_FFFF);
        write_word(12'd3071, {12'h000, 40'h4, 12'h001});
        write_word(12'd2559, 64'hFFFF_FFFF_FFFF_FFFF);
        translate_va(48'hFFFF_FFFF_FFFF);
        translate_va(48'hFFFF_FFFF_F000);
    endtask

    // Walk back up the same path, faulting at each lower level in turn.
    task automatic test_level_faults();
        write_word(12'd2559, 64'h0);
        translate_va(48'hFFFF_FFFF_FFFF);
        write_word(12'd3071, {12'h000, 40'hFF_FFFF_FFFF, 12'h001});
        translate_va(48'hFFFF_FFFF_FFFF);
        write_word(12'd3071, 64'h0);
        translate_va(48'hFFFF_FFFF_FFFF);
        write_word(12'd3583, {12'h000, 40'h8, 12'h001});
        translate_va(48'hFFFF_FFFF_FFFF);
        write_word(12'd3583, 64'h0);
        translate_va(48'hFFFF_FFFF_FFFF);
    endtask

    // One random item: noise write, revisit of a recent path, or a fresh address.
    task automatic random_item();
        logic [63:0] r;
        logic [47:0] va;
        int          k;
        k = $urandom_range(99);
        r = rand64();
        if (k < 10) begin
            send_item(pgwalk_pkg::CMD_WRITE, r[47:0], r[59:48], rand64());
        end else if (k < 55 && recent_va.size() > 0) begin
            va = recent_va[$urandom_range(recent_va.size() - 1)];
            case ($urandom_range(3))
                0: va[11:0] = r[11:0];
                1: va[20:0] = r[20:0];
                2: va[29:0] = r[29:0];
                default: ;
            endcase
            translate_va(va);
        end else begin
            translate_va(r[47:0]);
        end
    endtask

    // Phases of random traffic, cycling through root settings.
    task automatic test_random_walks();
        logic [63:0] r;
        logic [51:0] base;
        int          ph;
        int          budget;
        ph = 0;
        while (items_sent < ITEMS_TARGET) begin
            r = rand64();
            case (ph % 6)
                0: base = '0;
                2: base = 52'h0_0000_0000_7FFF;
                3: base = r[51:0] | 52'h0_0000_0000_8000;
                default: base = {37'h0, r[14:0]};
            endcase
            set_root(base);
            // outside roots fault at once, keep those phases short
            budget = items_sent + ((ph % 6 == 3) ? 20 : 200);
            calm   = (ph == 2);
            while (items_sent < budget && items_sent < ITEMS_TARGET)
                random_item();
            calm = 1'b0;
            ph++;
        end
    endtask

    // Hold the result channel for a long stretch while items keep coming.
    task automatic test_output_stall();
        logic [63:0] r;
        r = rand64();
        set_root({37'h0, r[14:0]});
        hold_cycles = STALL_CYCLES;
        repeat (40) random_item();
    endtask

    // Result side: take and check results, stall at random or on request.
    task automatic check_result();
        walk_result_t e;
        if (pending_xlat.size() == 0) begin
            report_mismatch("result with nothing pending", m_tdata, '0);
            return;
        end
        e = pending_xlat.pop_front();
        if (m_tdata[51:0] !== e.pa)
            report_mismatch("phys_addr", m_tdata[51:0], e.pa);
        if (m_tuser[0] !== e.ok)
            report_mismatch("ok", m_tuser[0], e.ok);
        if (m_tdata[53:52] !== e.size)
            report_mismatch("page_size", m_tdata[53:52], e.size);
        if (m_tuser[2:1] !== e.kind)
            report_mismatch("fault_kind", m_tuser[2:1], e.kind);
        if (m_tdata[55:54] !== e.lvl)
            report_mismatch("fault_level", m_tdata[55:54], e.lvl);
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                check_result();
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Give up on a hung run.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("four_level_page_table_walker test failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_root();
        test_root_outside();
        test_page_sizes();
        test_level_faults();
        test_random_walks();
        test_output_stall();
        drain_results();
        if (mismatches == 0 && pending_xlat.size() == 0)
            $display("four_level_page_table_walker test passed");
        else
            $display("four_level_page_table_walker test failed");
        $finish;
    end

endmodule
